// ===== design/hgp_pkg.sv =====
// Package: shared constants, types and counter helper for the hybrid predictor.
`default_nettype none
package hgp_pkg;

    // Default index widths of the three counter tables.
    localparam int GSHARE_BITS_DEF  = 18;
    localparam int GSELECT_BITS_DEF = 18;
    localparam int META_BITS_DEF    = 18;

    localparam int PC_W = 32;

    // Bit masks for the gselect index: history on even bits, pc on odd bits.
    localparam logic [PC_W-1:0] EVEN_BITS = 32'h5555_5555;
    localparam logic [PC_W-1:0] ODD_BITS  = 32'hAAAA_AAAA;

    // Signed 2-bit counter limits: -2 and 1.
    localparam logic [1:0] CTR_MIN  = 2'b10;
    localparam logic [1:0] CTR_MAX  = 2'b01;
    localparam logic [1:0] CTR_ZERO = 2'b00;

    // Request kinds.
    localparam logic REQ_PREDICT = 1'b0;
    localparam logic REQ_UPDATE  = 1'b1;

    // Queue between front and back; depth must be a power of two.
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // Step a saturating signed 2-bit counter towards the given direction.
    function automatic logic [1:0] ctr_step(input logic [1:0] ctr, input logic up);
        logic [1:0] res;
        res = ctr;
        if (up) begin
            if (ctr != CTR_MAX) res = ctr + 2'd1;
        end else begin
            if (ctr != CTR_MIN) res = ctr - 2'd1;
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// ===== design/hgp_if.sv =====
// Interfaces: request and response channels of the hybrid predictor.
`default_nettype none
interface hgp_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [31:0] pc;
    logic        is_conditional;
    logic        taken;

    modport source (output valid, output req_type, output pc, output is_conditional,
                    output taken, input ready);
    modport sink   (input valid, input req_type, input pc, input is_conditional,
                    input taken, output ready);
endinterface

interface hgp_rsp_if;
    logic valid;
    logic ready;
    logic prediction_valid;
    logic predicted_taken;
    logic chose_gshare;

    modport source (output valid, output prediction_valid, output predicted_taken,
                    output chose_gshare, input ready);
    modport sink   (input valid, input prediction_valid, input predicted_taken,
                    input chose_gshare, output ready);
endinterface
`default_nettype wire

// ===== design/hybrid_gshare_gselect_predictor.sv =====
// Top level: tournament branch predictor with gshare and gselect components.
`default_nettype none
// Branch predictor of the tournament kind. Each request on req is either a
// predict (fetch) or an update (retire) for one branch; every request gives
// exactly one result on rsp, in order. Predict requests for conditional
// branches return the direction and which component the meta table chose;
// all other requests return all-zero fields. Fetch and retire keep their own
// history registers, which the front updates as requests are accepted. After
// reset the three counter tables are swept to zero, one entry a cycle, over
// 2**max(index bits) entries (262144 at the default widths); req.ready stays
// low until the sweep ends. A request then passes through the back end in
// order: the registered table reads on pop, then S_EXEC, which trains the
// counters and loads the result register; the back takes no new request
// until S_EXEC is done. The back holds off the next table read until the
// previous write-back has landed. A two-entry queue lets the front keep
// accepting while the back waits on a stalled result.
module hybrid_gshare_gselect_predictor #(
    parameter int GSHARE_INDEX_BITS  = hgp_pkg::GSHARE_BITS_DEF,
    parameter int GSELECT_INDEX_BITS = hgp_pkg::GSELECT_BITS_DEF,
    parameter int META_INDEX_BITS    = hgp_pkg::META_BITS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    hgp_req_if.sink   req,
    hgp_rsp_if.source rsp
);
    import hgp_pkg::*;

    // History is as wide as the widest index.
    localparam int HIST_BITS =
        (GSHARE_INDEX_BITS > GSELECT_INDEX_BITS)
            ? ((GSHARE_INDEX_BITS > META_INDEX_BITS) ? GSHARE_INDEX_BITS : META_INDEX_BITS)
            : ((GSELECT_INDEX_BITS > META_INDEX_BITS) ? GSELECT_INDEX_BITS : META_INDEX_BITS);
    // Queue entry: request kind, conditional, taken and the three indices.
    localparam int ENTRY_W = 3 + GSHARE_INDEX_BITS + GSELECT_INDEX_BITS + META_INDEX_BITS;

    logic               push, pop, clear_done;
    logic [ENTRY_W-1:0] push_data, pop_data;
    q_status_t          q_status;

    // Front: take requests, advance history, form indices.
    hgp_front #(
        .GSHARE_INDEX_BITS  (GSHARE_INDEX_BITS),
        .GSELECT_INDEX_BITS (GSELECT_INDEX_BITS),
        .META_INDEX_BITS    (META_INDEX_BITS),
        .HIST_BITS          (HIST_BITS),
        .ENTRY_W            (ENTRY_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .clear_done (clear_done),
        .q_status   (q_status),
        .push       (push),
        .push_data  (push_data)
    );

    // Queue: hold classified requests until the back is free.
    hgp_queue #(
        .ENTRY_W (ENTRY_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .status    (q_status)
    );

    // Back: read, train and write the tables, drive the result.
    hgp_back #(
        .GSHARE_INDEX_BITS  (GSHARE_INDEX_BITS),
        .GSELECT_INDEX_BITS (GSELECT_INDEX_BITS),
        .META_INDEX_BITS    (META_INDEX_BITS),
        .HIST_BITS          (HIST_BITS),
        .ENTRY_W            (ENTRY_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_data     (pop_data),
        .q_status   (q_status),
        .pop        (pop),
        .clear_done (clear_done),
        .rsp        (rsp)
    );

endmodule
`default_nettype wire

// ===== design/hgp_front.sv =====
// Front: accepts requests, keeps both history registers and forms table indices.
`default_nettype none
module hgp_front #(
    parameter int GSHARE_INDEX_BITS  = hgp_pkg::GSHARE_BITS_DEF,
    parameter int GSELECT_INDEX_BITS = hgp_pkg::GSELECT_BITS_DEF,
    parameter int META_INDEX_BITS    = hgp_pkg::META_BITS_DEF,
    parameter int HIST_BITS          = 18,
    parameter int ENTRY_W            = 57
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    hgp_req_if.sink                   req,
    input  wire logic                 clear_done,
    input  wire hgp_pkg::q_status_t   q_status,
    output logic                      push,
    output logic [ENTRY_W-1:0]        push_data
);
    import hgp_pkg::*;

    logic [HIST_BITS-1:0] fetch_hist_reg, fetch_hist_next;
    logic [HIST_BITS-1:0] retire_hist_reg, retire_hist_next;
    logic [HIST_BITS-1:0] hist_sel;
    logic [PC_W-1:0]      hist_wide;
    logic [PC_W-1:0]      gs_wide;
    logic [PC_W-1:0]      gl_wide;
    logic                 shift_bit;

    assign req.ready = clear_done && !q_status.full;
    assign push      = req.valid && req.ready;

    // Pick the history of the stage that the request belongs to.
    assign hist_sel  = (req.req_type == REQ_UPDATE) ? retire_hist_reg : fetch_hist_reg;
    assign hist_wide = {{(PC_W-HIST_BITS){1'b0}}, hist_sel};
    assign gs_wide   = hist_wide ^ req.pc;
    assign gl_wide   = (hist_wide & EVEN_BITS) | (req.pc & ODD_BITS);
    assign shift_bit = req.is_conditional ? req.taken : 1'b1;

    assign push_data = {req.req_type, req.is_conditional, req.taken,
                        req.pc[META_INDEX_BITS-1:0],
                        gs_wide[GSHARE_INDEX_BITS-1:0],
                        gl_wide[GSELECT_INDEX_BITS-1:0]};

    always_comb
    begin
        fetch_hist_next  = fetch_hist_reg;
        retire_hist_next = retire_hist_reg;
        if (push)
        begin
            if (req.req_type == REQ_UPDATE)
                retire_hist_next = {retire_hist_reg[HIST_BITS-2:0], shift_bit};
            else
                fetch_hist_next = {fetch_hist_reg[HIST_BITS-2:0], shift_bit};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fetch_hist_reg  <= '0;
            retire_hist_reg <= '0;
        end
        else
        begin
            fetch_hist_reg  <= fetch_hist_next;
            retire_hist_reg <= retire_hist_next;
        end
    end

endmodule
`default_nettype wire

// ===== design/hgp_queue.sv =====
// Queue: short first-in first-out buffer between front and back.
`default_nettype none
module hgp_queue #(
    parameter int ENTRY_W = 57
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire logic [ENTRY_W-1:0]   push_data,
    input  wire logic                 pop,
    output logic [ENTRY_W-1:0]        pop_data,
    output hgp_pkg::q_status_t        status
);
    import hgp_pkg::*;

    logic [ENTRY_W-1:0] slot_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_PTR_W:0]   count_reg, count_next;

    assign status.full  = (count_reg == (Q_PTR_W+1)'(Q_DEPTH));
    assign status.empty = (count_reg == '0);
    assign pop_data     = slot_reg[rd_ptr_reg];

    // Pointers wrap naturally since the depth is a power of two.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !status.full)
        else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !status.empty)
        else $error("pop from empty queue");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (Q_PTR_W+1)'(Q_DEPTH))
        else $error("queue count beyond depth");

endmodule
`default_nettype wire

// ===== design/hgp_back.sv =====
// Back: counter tables, clearing sweep, read-modify-write and result register.
`default_nettype none
module hgp_back #(
    parameter int GSHARE_INDEX_BITS  = hgp_pkg::GSHARE_BITS_DEF,
    parameter int GSELECT_INDEX_BITS = hgp_pkg::GSELECT_BITS_DEF,
    parameter int META_INDEX_BITS    = hgp_pkg::META_BITS_DEF,
    parameter int HIST_BITS          = 18,
    parameter int ENTRY_W            = 57
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic [ENTRY_W-1:0]   q_data,
    input  wire hgp_pkg::q_status_t   q_status,
    output logic                      pop,
    output logic                      clear_done,
    hgp_rsp_if.source                 rsp
);
    import hgp_pkg::*;

    localparam int L_LO  = 0;
    localparam int S_LO  = GSELECT_INDEX_BITS;
    localparam int M_LO  = S_LO + GSHARE_INDEX_BITS;
    localparam int TK_B  = M_LO + META_INDEX_BITS;
    localparam int CD_B  = TK_B + 1;
    localparam int RT_B  = TK_B + 2;

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_EXEC  = 3'b100
    } state_t;

    state_t               state_reg, state_next;
    logic [HIST_BITS-1:0] clr_reg, clr_next;
    logic [ENTRY_W-1:0]   entry_reg;

    logic [1:0] gs_mem   [2**GSHARE_INDEX_BITS];
    logic [1:0] gl_mem   [2**GSELECT_INDEX_BITS];
    logic [1:0] meta_mem [2**META_INDEX_BITS];
    logic [1:0] gs_rd_reg, gl_rd_reg, meta_rd_reg;

    logic                          clearing, exec_fire;
    logic                          e_upd, e_cond, e_taken, use_gs, gs_right, gl_right;
    logic [GSHARE_INDEX_BITS-1:0]  gs_waddr;
    logic [GSELECT_INDEX_BITS-1:0] gl_waddr;
    logic [META_INDEX_BITS-1:0]    meta_waddr;
    logic [1:0]                    gs_wdata, gl_wdata, meta_wdata;
    logic                          gs_we, gl_we, meta_we;
    logic                          train;

    logic rsp_valid_reg, rsp_valid_next;
    logic pv_reg, pt_reg, cg_reg;

    assign clearing   = (state_reg == S_CLEAR);
    assign clear_done = !clearing;
    assign pop        = (state_reg == S_IDLE) && !q_status.empty;
    assign exec_fire  = (state_reg == S_EXEC) && (!rsp_valid_reg || rsp.ready);

    assign e_upd    = (entry_reg[RT_B] == REQ_UPDATE);
    assign e_cond   = entry_reg[CD_B];
    assign e_taken  = entry_reg[TK_B];
    assign use_gs   = !meta_rd_reg[1];
    assign gs_right = (!gs_rd_reg[1]) == e_taken;
    assign gl_right = (!gl_rd_reg[1]) == e_taken;
    assign train    = exec_fire && e_upd && e_cond;

    // Write ports: zeros during the sweep, trained counters otherwise.
    always_comb
    begin
        if (clearing)
        begin
            gs_waddr   = clr_reg[GSHARE_INDEX_BITS-1:0];
            gl_waddr   = clr_reg[GSELECT_INDEX_BITS-1:0];
            meta_waddr = clr_reg[META_INDEX_BITS-1:0];
            gs_wdata   = CTR_ZERO;
            gl_wdata   = CTR_ZERO;
            meta_wdata = CTR_ZERO;
            gs_we      = 1'b1;
            gl_we      = 1'b1;
            meta_we    = 1'b1;
        end
        else
        begin
            gs_waddr   = entry_reg[S_LO +: GSHARE_INDEX_BITS];
            gl_waddr   = entry_reg[L_LO +: GSELECT_INDEX_BITS];
            meta_waddr = entry_reg[M_LO +: META_INDEX_BITS];
            gs_wdata   = ctr_step(gs_rd_reg, e_taken);
            gl_wdata   = ctr_step(gl_rd_reg, e_taken);
            meta_wdata = ctr_step(meta_rd_reg, gs_right);
            gs_we      = train && use_gs;
            gl_we      = train && !use_gs;
            meta_we    = train && (gs_right != gl_right);
        end
    end

    always_ff @(posedge clk)
    begin
        if (gs_we)
            gs_mem[gs_waddr] <= gs_wdata;
        if (pop)
            gs_rd_reg <= gs_mem[q_data[S_LO +: GSHARE_INDEX_BITS]];
    end

    always_ff @(posedge clk)
    begin
        if (gl_we)
            gl_mem[gl_waddr] <= gl_wdata;
        if (pop)
            gl_rd_reg <= gl_mem[q_data[L_LO +: GSELECT_INDEX_BITS]];
    end

    always_ff @(posedge clk)
    begin
        if (meta_we)
            meta_mem[meta_waddr] <= meta_wdata;
        if (pop)
            meta_rd_reg <= meta_mem[q_data[M_LO +: META_INDEX_BITS]];
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && rsp.ready)
            rsp_valid_next = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (&clr_reg)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (pop)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (exec_fire)
                begin
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            entry_reg <= q_data;
        if (exec_fire)
        begin
            pv_reg <= !e_upd && e_cond;
            pt_reg <= !e_upd && e_cond && (use_gs ? !gs_rd_reg[1] : !gl_rd_reg[1]);
            cg_reg <= !e_upd && e_cond && use_gs;
        end
    end

    assign rsp.valid            = rsp_valid_reg;
    assign rsp.prediction_valid = pv_reg;
    assign rsp.predicted_taken  = pt_reg;
    assign rsp.chose_gshare     = cg_reg;

    a_no_rsp_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !rsp_valid_reg)
        else $error("result shown during table sweep");
    a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !pop)
        else $error("request taken during table sweep");
    a_fire_shows: assert property (@(posedge clk) disable iff (!rst_n)
        exec_fire |=> rsp_valid_reg)
        else $error("finished request produced no result");

endmodule
`default_nettype wire
